// ===== rtl/core/xoshiro256pp_random_generator_macros.svh =====
// Assertion macros shared by the xoshiro256++ generator checker.
// No dependencies; include with the bare file name.
`ifndef XOSHIRO256PP_RANDOM_GENERATOR_MACROS_SVH
`define XOSHIRO256PP_RANDOM_GENERATOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define XRNG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xrng checker: same-cycle property failed");

// next-cycle implication, checked outside reset
`define XRNG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xrng checker: next-cycle property failed");

`endif

// ===== rtl/core/xrng_pkg.sv =====
// Package for the xoshiro256++ generator: widths, constants, command types.
// No dependencies.
package xrng_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned FRAC_W      = 53;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d049bb133111eb;

  typedef enum logic [1:0] {
    KIND_SEED  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_DRAW  = 2'd2,
    KIND_RANGE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_TOO_LARGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_SEED   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_DRAW   = 3'd2,
    OP_RANGE  = 3'd3,
    OP_REJECT = 3'd4
  } op_t;

  // w0: seed / load word 0 / range low; w1: load word 1 / interval size
  typedef struct packed {
    op_t               op;
    status_t           status;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [WORD_W-1:0] w3;
  } cmd_t;

endpackage

// ===== rtl/core/xoshiro256pp_random_generator.sv =====
// Load, raw draw and rejected ranged draw go from the idle state through ST_OUT
// to the output register; a ranged draw first runs a 64-step serial remainder,
// a seed four splitmix64 steps, each two multiplies of three 32x32 passes.
// One item is worked at a time in the back end; a 2-entry queue and the
// output register let input and output stall independently.
// Synchronous active-low reset zeroes the generator state and empties queue.
module xoshiro256pp_random_generator #(
  parameter int unsigned QUEUE_DEPTH = xrng_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_kind,
  input  logic [xrng_pkg::WORD_W-1:0]        in_seed_value,
  input  logic [xrng_pkg::WORD_W-1:0]        in_load_word0,
  input  logic [xrng_pkg::WORD_W-1:0]        in_load_word1,
  input  logic [xrng_pkg::WORD_W-1:0]        in_load_word2,
  input  logic [xrng_pkg::WORD_W-1:0]        in_load_word3,
  input  logic signed [xrng_pkg::WORD_W-1:0] in_range_low,
  input  logic signed [xrng_pkg::WORD_W-1:0] in_range_high,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [xrng_pkg::WORD_W-1:0]        out_random_word,
  output logic [xrng_pkg::FRAC_W-1:0]        out_fraction_bits,
  output logic signed [xrng_pkg::WORD_W-1:0] out_ranged_value,
  output logic [1:0]                         out_status,
  output logic [xrng_pkg::WORD_W-1:0]        out_state_out0,
  output logic [xrng_pkg::WORD_W-1:0]        out_state_out1,
  output logic [xrng_pkg::WORD_W-1:0]        out_state_out2,
  output logic [xrng_pkg::WORD_W-1:0]        out_state_out3
);
  import xrng_pkg::*;

  cmd_t front_cmd, back_cmd;
  logic front_valid, front_ready, back_valid, back_ready;

  xrng_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_seed_value (in_seed_value),
    .in_load_word0 (in_load_word0),
    .in_load_word1 (in_load_word1),
    .in_load_word2 (in_load_word2),
    .in_load_word3 (in_load_word3),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  xrng_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_cmd)
  );

  xrng_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (back_valid),
    .cmd_ready         (back_ready),
    .cmd               (back_cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_random_word   (out_random_word),
    .out_fraction_bits (out_fraction_bits),
    .out_ranged_value  (out_ranged_value),
    .out_status        (out_status),
    .out_state_out0    (out_state_out0),
    .out_state_out1    (out_state_out1),
    .out_state_out2    (out_state_out2),
    .out_state_out3    (out_state_out3)
  );

endmodule

// ===== rtl/core/xrng_front.sv =====
// Front end: accepts input beats and classifies them into commands.
// Depends on xrng_pkg.
module xrng_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [xrng_pkg::WORD_W-1:0]   in_seed_value,
  input  logic [xrng_pkg::WORD_W-1:0]   in_load_word0,
  input  logic [xrng_pkg::WORD_W-1:0]   in_load_word1,
  input  logic [xrng_pkg::WORD_W-1:0]   in_load_word2,
  input  logic [xrng_pkg::WORD_W-1:0]   in_load_word3,
  input  logic signed [xrng_pkg::WORD_W-1:0] in_range_low,
  input  logic signed [xrng_pkg::WORD_W-1:0] in_range_high,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output xrng_pkg::cmd_t                cmd
);
  import xrng_pkg::*;

  logic [WORD_W-1:0] diff;

  assign diff      = in_range_high - in_range_low;
  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;

  always_comb begin
    cmd.op     = OP_LOAD;
    cmd.status = STATUS_OK;
    cmd.w0     = in_load_word0;
    cmd.w1     = in_load_word1;
    cmd.w2     = in_load_word2;
    cmd.w3     = in_load_word3;
    case (kind_t'(in_kind))
      KIND_SEED: begin
        cmd.op = OP_SEED;
        cmd.w0 = in_seed_value;
      end
      KIND_LOAD: cmd.op = OP_LOAD;
      KIND_DRAW: cmd.op = OP_DRAW;
      KIND_RANGE: begin
        cmd.w0 = in_range_low;
        cmd.w1 = diff + 64'd1;
        if (in_range_low > in_range_high) begin
          cmd.op     = OP_REJECT;
          cmd.status = STATUS_EMPTY;
        end else if (diff[WORD_W-1]) begin
          cmd.op     = OP_REJECT;
          cmd.status = STATUS_TOO_LARGE;
        end else begin
          cmd.op = OP_RANGE;
        end
      end
      default: cmd.op = OP_LOAD;
    endcase
  end

endmodule

// ===== rtl/core/xrng_queue.sv =====
// Command queue between front and back ends.
// Depends on xrng_pkg.
module xrng_queue #(
  parameter int unsigned DEPTH = xrng_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  xrng_pkg::cmd_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output xrng_pkg::cmd_t pop_data
);
  import xrng_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/xrng_back.sv =====
// Back end: generator state, splitmix64 seeding, draws, serial remainder,
// output register. Depends on xrng_pkg.
module xrng_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  xrng_pkg::cmd_t                    cmd,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [xrng_pkg::WORD_W-1:0]       out_random_word,
  output logic [xrng_pkg::FRAC_W-1:0]       out_fraction_bits,
  output logic signed [xrng_pkg::WORD_W-1:0] out_ranged_value,
  output logic [1:0]                        out_status,
  output logic [xrng_pkg::WORD_W-1:0]       out_state_out0,
  output logic [xrng_pkg::WORD_W-1:0]       out_state_out1,
  output logic [xrng_pkg::WORD_W-1:0]       out_state_out2,
  output logic [xrng_pkg::WORD_W-1:0]       out_state_out3
);
  import xrng_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MIX  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [WORD_W-1:0] s_r [4];
  op_t               op_r;
  status_t           res_status_r;
  logic [WORD_W-1:0] res_word_r, lo_r, div_r, rem_r, word_sh_r;
  logic [5:0]        cnt_r;
  logic [WORD_W-1:0] acc_r, mul_a_r, prod_r;
  logic [1:0]        mstep_r, widx_r;
  logic              mix_sel_r;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r, out_ranged_r, out_s0_r, out_s1_r, out_s2_r, out_s3_r;
  status_t           out_status_r;

  // one xoshiro256++ step
  logic [WORD_W-1:0] adv_sum, adv_out, t17, n0, n1, n2, n3;
  assign adv_sum = s_r[0] + s_r[3];
  assign adv_out = {adv_sum[40:0], adv_sum[63:41]} + s_r[0];
  assign t17     = s_r[1] << 17;
  assign n2      = s_r[2] ^ s_r[0];
  assign n3      = s_r[3] ^ s_r[1];
  assign n1      = s_r[1] ^ n2;
  assign n0      = s_r[0] ^ n3;

  // 64x64 low product built from three 32x32 partial products
  logic [WORD_W-1:0] mul_b, term, prod_nxt, seed_acc, next_acc, next_acc_pre;
  logic [31:0]       a_half, b_half;
  assign mul_b    = mix_sel_r ? MIX_MUL_B : MIX_MUL_A;
  assign a_half   = (mstep_r == 2'd2) ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_half   = (mstep_r == 2'd1) ? mul_b[63:32] : mul_b[31:0];
  assign term     = {32'd0, a_half} * {32'd0, b_half};
  assign prod_nxt = (mstep_r == 2'd0) ? term : prod_r + {term[31:0], 32'd0};
  assign seed_acc = cmd.w0 + GOLDEN_INC;
  assign next_acc = acc_r + GOLDEN_INC;
  assign next_acc_pre = next_acc ^ (next_acc >> 30);

  // restoring remainder step
  logic [WORD_W:0] trial;
  assign trial = {rem_r, word_sh_r[WORD_W-1]};

  logic load_out;
  assign load_out  = (state_r == ST_OUT) && (!out_valid_r || out_ready);
  assign cmd_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            OP_SEED:  state_nxt = ST_MIX;
            OP_RANGE: state_nxt = ST_DIV;
            default:  state_nxt = ST_OUT;
          endcase
        end
      end
      ST_MIX: begin
        if (mstep_r == 2'd2 && mix_sel_r && widx_r == 2'd3) state_nxt = ST_OUT;
      end
      ST_DIV: begin
        if (cnt_r == '0) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s_r[0]  <= '0;
      s_r[1]  <= '0;
      s_r[2]  <= '0;
      s_r[3]  <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            op_r         <= cmd.op;
            res_status_r <= cmd.status;
            res_word_r   <= '0;
            case (cmd.op)
              OP_SEED: begin
                acc_r     <= seed_acc;
                mul_a_r   <= seed_acc ^ (seed_acc >> 30);
                mix_sel_r <= 1'b0;
                mstep_r   <= 2'd0;
                widx_r    <= 2'd0;
              end
              OP_LOAD: begin
                s_r[0] <= cmd.w0;
                s_r[1] <= cmd.w1;
                s_r[2] <= cmd.w2;
                s_r[3] <= cmd.w3;
              end
              OP_DRAW, OP_RANGE: begin
                s_r[0]     <= n0;
                s_r[1]     <= n1;
                s_r[2]     <= n2 ^ t17;
                s_r[3]     <= {n3[18:0], n3[63:19]};
                res_word_r <= adv_out;
                word_sh_r  <= adv_out;
                lo_r       <= cmd.w0;
                div_r      <= cmd.w1;
                rem_r      <= '0;
                cnt_r      <= 6'd63;
              end
              default: res_word_r <= '0;
            endcase
          end
        end
        ST_MIX: begin
          prod_r  <= prod_nxt;
          mstep_r <= (mstep_r == 2'd2) ? 2'd0 : mstep_r + 2'd1;
          if (mstep_r == 2'd2) begin
            if (!mix_sel_r) begin
              mul_a_r   <= prod_nxt ^ (prod_nxt >> 27);
              mix_sel_r <= 1'b1;
            end else begin
              s_r[widx_r] <= prod_nxt ^ (prod_nxt >> 31);
              acc_r       <= next_acc;
              mul_a_r     <= next_acc_pre;
              mix_sel_r   <= 1'b0;
              widx_r      <= widx_r + 2'd1;
            end
          end
        end
        ST_DIV: begin
          word_sh_r <= word_sh_r << 1;
          cnt_r     <= cnt_r - 6'd1;
          if (trial >= {1'b0, div_r}) begin
            rem_r <= WORD_W'(trial - {1'b0, div_r});
          end else begin
            rem_r <= trial[WORD_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r   <= res_word_r;
      out_ranged_r <= (op_r == OP_RANGE) ? lo_r + rem_r : '0;
      out_status_r <= res_status_r;
      out_s0_r     <= s_r[0];
      out_s1_r     <= s_r[1];
      out_s2_r     <= s_r[2];
      out_s3_r     <= s_r[3];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_random_word   = out_word_r;
  assign out_fraction_bits = out_word_r[WORD_W-1:WORD_W-FRAC_W];
  assign out_ranged_value  = out_ranged_r;
  assign out_status        = out_status_r;
  assign out_state_out0    = out_s0_r;
  assign out_state_out1    = out_s1_r;
  assign out_state_out2    = out_s2_r;
  assign out_state_out3    = out_s3_r;

endmodule

// ===== rtl/core/xrng_checker.sv =====
// Port-level checker for the xoshiro256++ generator, bound to the top level.
// Depends on xrng_pkg and xoshiro256pp_random_generator_macros.svh.
`include "xoshiro256pp_random_generator_macros.svh"
module xrng_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [xrng_pkg::WORD_W-1:0]        out_random_word,
  input logic [xrng_pkg::FRAC_W-1:0]        out_fraction_bits,
  input logic signed [xrng_pkg::WORD_W-1:0] out_ranged_value,
  input logic [1:0]                         out_status
);
  import xrng_pkg::*;

  logic status_known, reject_beat, reject_clean;

  assign status_known = (out_status == STATUS_OK) || (out_status == STATUS_EMPTY) ||
                        (out_status == STATUS_TOO_LARGE);
  assign reject_beat  = out_valid && (out_status != STATUS_OK);
  assign reject_clean = (out_random_word == '0) && (out_ranged_value == '0);

  `XRNG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_random_word))
  `XRNG_ASSERT_NOW(a_frac_top, out_valid, out_fraction_bits == out_random_word[63:11])
  `XRNG_ASSERT_NOW(a_reject_zero, reject_beat, reject_clean)
  `XRNG_ASSERT_NOW(a_status_code, out_valid, status_known)

endmodule

bind xoshiro256pp_random_generator xrng_checker u_xrng_checker (.*);
